/* rtl/tk_pkg.sv */
// Shared constants, command/status types and the ranking and sentinel functions of the top-k unit.
package tk_pkg;

    localparam int K_MAX          = 16;
    localparam int VALUE_BITS     = 32;
    localparam int INDEX_BITS     = 16;
    localparam int SLOT_BITS      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int COUNT_BITS     = $clog2(K_MAX + 1);
    localparam int KCFG_BITS      = 5;
    localparam int CFG_DATA_BITS  = 5;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE_MIN      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_K_COUNT       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VALUES_SIGNED = 2'd2;

    localparam logic [VALUE_BITS-1:0] VAL_SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 take_in;
        logic                 decide;
        logic                 scan_load;
        logic                 scan_step;
        logic                 sort_load;
        logic                 sort_step;
        logic                 emit;
        logic                 emit_last;
        logic                 row_init;
        logic [SLOT_BITS-1:0] rd_slot;
    } tk_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic                  inserted;
        logic                  row_last;
        logic                  out_free;
        logic [COUNT_BITS-1:0] k_eff;
    } tk_stat_t;

    // True when (cv, ci) ranks strictly better than (uv, ui)
    function automatic logic tk_better(
        input logic [VALUE_BITS-1:0] cv,
        input logic [INDEX_BITS-1:0] ci,
        input logic [VALUE_BITS-1:0] uv,
        input logic [INDEX_BITS-1:0] ui,
        input logic                  mode_min,
        input logic                  is_signed
    );
        logic [VALUE_BITS-1:0] kc;
        logic [VALUE_BITS-1:0] ku;
        logic                  gt;
        kc = is_signed ? (cv ^ VAL_SIGN) : cv;
        ku = is_signed ? (uv ^ VAL_SIGN) : uv;
        gt = mode_min ? (kc < ku) : (kc > ku);
        return gt || ((kc == ku) && (ci < ui));
    endfunction

    // Worst possible value for the given ordering
    function automatic logic [VALUE_BITS-1:0] tk_sentinel(
        input logic mode_min,
        input logic is_signed
    );
        logic [VALUE_BITS-1:0] s;
        if (mode_min)
        begin
            s = is_signed ? ~VAL_SIGN : {VALUE_BITS{1'b1}};
        end
        else
        begin
            s = is_signed ? VAL_SIGN : '0;
        end
        return s;
    endfunction

endpackage

/* rtl/topk_select_sort_unit.sv */
// Top level of the streaming top-k selection and sort unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | sink      | in_valid/in_stall  | elem_value[31:0], row_last
//  out     | source    | out_valid/out_stall| out_value[31:0], out_index[15:0], out_last
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[4:0]
//
// A rejected element is accepted and decided; an inserted element goes through accept, insert,
// then a k-slot worst scan over the single read port of the slot file.
// On a row end a selection sort emits the k slots in rank order, each emit waiting on out_stall.
// Reset loads all slots with the sentinel at once; there is no clearing pass.
// The output register lets the next element enter while the last result beat still waits.
module topk_select_sort_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tk_pkg::VALUE_BITS-1:0]     elem_value,
    input  logic                              row_last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tk_pkg::VALUE_BITS-1:0]     out_value,
    output logic [tk_pkg::INDEX_BITS-1:0]     out_index,
    output logic                              out_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tk_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import tk_pkg::*;

    tk_cmd_t  cmd;
    tk_stat_t stat;

    tk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tk_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .elem_value (elem_value),
        .row_last   (row_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .out_index  (out_index),
        .out_last   (out_last)
    );

endmodule

/* rtl/tk_ctrl.sv */
// Sequencing controller of the top-k unit: insert, worst-slot scan, sort and emit.
module tk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             cfg_ready,
    input  tk_pkg::tk_stat_t stat,
    output tk_pkg::tk_cmd_t  cmd
);
    import tk_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_LOAD,
        ST_SCAN,
        ST_SORT_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_BITS-1:0] cnt_i_reg, cnt_i_next;
    logic [COUNT_BITS-1:0] cnt_j_reg, cnt_j_next;
    logic                  i_is_last;
    logic                  j_is_last;

    assign i_is_last = ((cnt_i_reg + COUNT_BITS'(1)) == stat.k_eff);
    assign j_is_last = ((cnt_j_reg + COUNT_BITS'(1)) == stat.k_eff);

    // Take new beats and config writes only when idle
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // Decode state into datapath commands and next state
    always_comb
    begin
        state_next = state_reg;
        cnt_i_next = cnt_i_reg;
        cnt_j_next = cnt_j_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                cnt_i_next = '0;
                if (stat.inserted)
                begin
                    state_next = ST_SCAN_LOAD;
                end
                else if (stat.row_last)
                begin
                    state_next = ST_SORT_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_LOAD:
            begin
                cmd.scan_load = 1'b1;
                cmd.rd_slot   = '0;
                cnt_j_next    = COUNT_BITS'(1);
                if (stat.k_eff == COUNT_BITS'(1))
                begin
                    state_next = stat.row_last ? ST_SORT_LOAD : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.rd_slot   = cnt_j_reg[SLOT_BITS-1:0];
                cnt_j_next    = cnt_j_reg + COUNT_BITS'(1);
                if (j_is_last)
                begin
                    state_next = stat.row_last ? ST_SORT_LOAD : ST_IDLE;
                end
            end
            ST_SORT_LOAD:
            begin
                cmd.sort_load = 1'b1;
                cmd.rd_slot   = cnt_i_reg[SLOT_BITS-1:0];
                cnt_j_next    = cnt_i_reg + COUNT_BITS'(1);
                state_next    = i_is_last ? ST_EMIT : ST_SORT;
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.rd_slot   = cnt_j_reg[SLOT_BITS-1:0];
                cnt_j_next    = cnt_j_reg + COUNT_BITS'(1);
                if (j_is_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = i_is_last;
                    if (i_is_last)
                    begin
                        cmd.row_init = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cnt_i_next = cnt_i_reg + COUNT_BITS'(1);
                        state_next = ST_SORT_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_i_reg <= '0;
            cnt_j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_i_reg <= cnt_i_next;
            cnt_j_reg <= cnt_j_next;
        end
    end

endmodule

/* rtl/tk_datapath.sv */
// Datapath of the top-k unit: config registers, slot file, compare unit and output register.
module tk_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tk_pkg::tk_cmd_t                      cmd,
    output tk_pkg::tk_stat_t                     stat,
    input  logic [tk_pkg::VALUE_BITS-1:0]        elem_value,
    input  logic                                 row_last,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [tk_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [tk_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tk_pkg::VALUE_BITS-1:0]        out_value,
    output logic [tk_pkg::INDEX_BITS-1:0]        out_index,
    output logic                                 out_last
);
    import tk_pkg::*;

    // Configuration
    logic                  mode_min_reg, mode_min_next;
    logic [KCFG_BITS-1:0]  k_count_reg, k_count_next;
    logic                  values_signed_reg, values_signed_next;
    logic                  cfg_we;
    logic                  cfg_known;
    logic                  cfg_init;
    logic [COUNT_BITS-1:0] k_eff;

    // Slot file and row state
    logic [VALUE_BITS-1:0] slot_val_reg [K_MAX];
    logic [INDEX_BITS-1:0] slot_idx_reg [K_MAX];
    logic [COUNT_BITS-1:0] fill_count_reg;
    logic [SLOT_BITS-1:0]  worst_slot_reg;
    logic [INDEX_BITS-1:0] elem_pos_reg;

    // Working registers
    logic [VALUE_BITS-1:0] in_val_reg;
    logic                  in_last_reg;
    logic [VALUE_BITS-1:0] cur_val_reg;
    logic [INDEX_BITS-1:0] cur_idx_reg;

    // Output register
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [INDEX_BITS-1:0] out_index_reg;
    logic                  out_last_reg;

    logic [SLOT_BITS-1:0]  rd_addr;
    logic [VALUE_BITS-1:0] rd_val;
    logic [INDEX_BITS-1:0] rd_idx;
    logic                  room;
    logic                  ins;
    logic                  scan_take;
    logic                  sort_swap;
    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_slot;
    logic [VALUE_BITS-1:0] wr_val;
    logic [INDEX_BITS-1:0] wr_idx;
    logic [VALUE_BITS-1:0] sentinel;

    // Decode config writes; next values feed the refill sentinel
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == CFG_MODE_MIN) || (cfg_index == CFG_K_COUNT) ||
                       (cfg_index == CFG_VALUES_SIGNED);
    assign cfg_init  = cfg_we && cfg_known && (elem_pos_reg == '0);

    always_comb
    begin
        mode_min_next      = mode_min_reg;
        k_count_next       = k_count_reg;
        values_signed_next = values_signed_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_MODE_MIN)
            begin
                mode_min_next = cfg_data[0];
            end
            else if (cfg_index == CFG_K_COUNT)
            begin
                k_count_next = cfg_data[KCFG_BITS-1:0];
            end
            else if (cfg_index == CFG_VALUES_SIGNED)
            begin
                values_signed_next = cfg_data[0];
            end
        end
    end

    assign sentinel = tk_sentinel(mode_min_next, values_signed_next);

    // Clamp k into 1..K_MAX
    always_comb
    begin
        if (k_count_reg == '0)
        begin
            k_eff = COUNT_BITS'(1);
        end
        else if (int'(k_count_reg) > K_MAX)
        begin
            k_eff = COUNT_BITS'(K_MAX);
        end
        else
        begin
            k_eff = COUNT_BITS'(k_count_reg);
        end
    end

    // Single read port of the slot file
    assign rd_addr = cmd.decide ? worst_slot_reg : cmd.rd_slot;
    assign rd_val  = slot_val_reg[rd_addr];
    assign rd_idx  = slot_idx_reg[rd_addr];

    // Compare units for insert, scan and sort, all fed from the single read port
    assign room      = (fill_count_reg < k_eff);
    assign ins       = room || tk_better(in_val_reg, elem_pos_reg, rd_val, rd_idx,
                                         mode_min_reg, values_signed_reg);
    assign scan_take = tk_better(cur_val_reg, cur_idx_reg, rd_val, rd_idx,
                                 mode_min_reg, values_signed_reg);
    assign sort_swap = tk_better(rd_val, rd_idx, cur_val_reg, cur_idx_reg,
                                 mode_min_reg, values_signed_reg);

    // Select the slot write: insert of a new element or a sort swap
    always_comb
    begin
        wr_en   = 1'b0;
        wr_slot = cmd.rd_slot;
        wr_val  = cur_val_reg;
        wr_idx  = cur_idx_reg;
        if (cmd.decide && ins)
        begin
            wr_en   = 1'b1;
            wr_slot = room ? fill_count_reg[SLOT_BITS-1:0] : worst_slot_reg;
            wr_val  = in_val_reg;
            wr_idx  = elem_pos_reg;
        end
        else if (cmd.sort_step && sort_swap)
        begin
            wr_en = 1'b1;
        end
    end

    assign stat.inserted = ins;
    assign stat.row_last = in_last_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.k_eff    = k_eff;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_min_reg      <= 1'b0;
            k_count_reg       <= KCFG_BITS'(1);
            values_signed_reg <= 1'b1;
        end
        else
        begin
            mode_min_reg      <= mode_min_next;
            k_count_reg       <= k_count_next;
            values_signed_reg <= values_signed_next;
        end
    end

    // Refill, insert or swap slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < K_MAX; s++)
            begin
                slot_val_reg[s] <= VAL_SIGN;
                slot_idx_reg[s] <= '0;
            end
        end
        else if (cfg_init || cmd.row_init)
        begin
            for (int s = 0; s < K_MAX; s++)
            begin
                slot_val_reg[s] <= sentinel;
                slot_idx_reg[s] <= '0;
            end
        end
        else if (wr_en)
        begin
            slot_val_reg[wr_slot] <= wr_val;
            slot_idx_reg[wr_slot] <= wr_idx;
        end
    end

    // Track fill count, worst slot and element position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            worst_slot_reg <= '0;
            elem_pos_reg   <= '0;
        end
        else if (cfg_init || cmd.row_init)
        begin
            fill_count_reg <= '0;
            worst_slot_reg <= '0;
            elem_pos_reg   <= '0;
        end
        else
        begin
            if (cmd.decide)
            begin
                elem_pos_reg <= elem_pos_reg + INDEX_BITS'(1);
                if (room)
                begin
                    fill_count_reg <= fill_count_reg + COUNT_BITS'(1);
                end
            end
            if (cmd.scan_load)
            begin
                worst_slot_reg <= '0;
            end
            else if (cmd.scan_step && scan_take)
            begin
                worst_slot_reg <= rd_addr;
            end
        end
    end

    // Latch the input beat and the running scan/sort candidate
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            in_val_reg  <= elem_value;
            in_last_reg <= row_last;
        end
        if (cmd.scan_load || cmd.sort_load || (cmd.scan_step && scan_take) ||
            (cmd.sort_step && sort_swap))
        begin
            cur_val_reg <= rd_val;
            cur_idx_reg <= rd_idx;
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg <= cur_val_reg;
            out_index_reg <= cur_idx_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

/* rtl/tk_checker.sv */
// Port-level checks of the top-k unit and their binding to the top level.
module tk_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [tk_pkg::VALUE_BITS-1:0]     elem_value,
    input logic                              row_last,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [tk_pkg::VALUE_BITS-1:0]     out_value,
    input logic [tk_pkg::INDEX_BITS-1:0]     out_index,
    input logic                              out_last,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [tk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [tk_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import tk_pkg::*;

    // A stalled result beat holds valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_value) &&
                                   $stable(out_index) && $stable(out_last))
        else $error("result beat changed while stalled");

    // A stalled input beat stays offered with its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(elem_value) && $stable(row_last))
        else $error("input beat withdrawn or changed while stalled");

    // A waiting config write holds its index and data
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && !cfg_ready |=> cfg_valid && $stable(cfg_index) && $stable(cfg_data))
        else $error("config write changed while waiting");

    // An accepted element keeps the unit busy for the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second element taken before the first was processed");

    // Config writes are open exactly when elements are
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !in_stall)
        else $error("config port open while the unit is busy");

endmodule

bind topk_select_sort_unit tk_checker u_tk_checker (.*);
